### hw/rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types, codes and constants of the interval set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int POS_W             = 32;
    localparam int COUNT_W           = 6;
    localparam int DEF_MAX_INTERVALS = 32;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_SAME   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_RANGE = 2'd2
    } status_t;

    // Per-cell operation for one clock
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        pos_t left;
        pos_t right;
    } seg_t;

    // Compare results of one cell against the request held in the controller
    typedef struct packed {
        logic ins_below;
        logic ins_above;
        logic rem_below;
        logic rem_above;
        logic hold_a;
        logic hold_b;
    } cell_flags_t;

    typedef struct packed {
        cmd_t cmd;
        pos_t pos_a;
        pos_t pos_b;
    } req_item_t;

    typedef struct packed {
        status_t             status;
        logic                found;
        pos_t                seg_left;
        pos_t                seg_right;
        logic                same_interval;
        logic [COUNT_W-1:0]  interval_count;
    } rsp_item_t;

endpackage

### hw/rtl/ist_cell.sv
// ----------------------------------------------------------------------------
// ist_cell
// One slot of the interval table: holds one interval, compares it against
// the current request and takes a neighbor's interval on a shift.
// ----------------------------------------------------------------------------
module ist_cell (
    input  logic              clk,
    input  ist_pkg::cell_op_t op,
    input  ist_pkg::seg_t     from_left,
    input  ist_pkg::seg_t     from_right,
    input  ist_pkg::seg_t     load_seg,
    input  ist_pkg::pos_t     req_a,
    input  ist_pkg::pos_t     req_b,
    input  logic              merge_adj,
    output ist_pkg::seg_t     seg,
    output ist_pkg::cell_flags_t flags
);
    import ist_pkg::*;

    seg_t seg_reg;
    logic signed [POS_W:0] left_x;
    logic signed [POS_W:0] right_x;
    logic signed [POS_W:0] a_x;
    logic signed [POS_W:0] b_x;

    // Hold, shift or load the stored interval
    always_ff @(posedge clk)
    begin
        unique case (op)
            CELL_HOLD:       seg_reg <= seg_reg;
            CELL_FROM_LEFT:  seg_reg <= from_left;
            CELL_FROM_RIGHT: seg_reg <= from_right;
            CELL_LOAD:       seg_reg <= load_seg;
            default:         seg_reg <= seg_reg;
        endcase
    end

    assign seg = seg_reg;

    // Adjacency is tested one bit wider so that end + 1 never wraps
    always_comb
    begin
        left_x  = {seg_reg.left[POS_W-1], seg_reg.left};
        right_x = {seg_reg.right[POS_W-1], seg_reg.right};
        a_x     = {req_a[POS_W-1], req_a};
        b_x     = {req_b[POS_W-1], req_b};
        flags.ins_below = !(seg_reg.right >= req_a ||
                            (merge_adj && (right_x + (POS_W+1)'(1)) == a_x));
        flags.ins_above = !(seg_reg.left <= req_b ||
                            (merge_adj && left_x == (b_x + (POS_W+1)'(1))));
        flags.rem_below = seg_reg.right < req_a;
        flags.rem_above = seg_reg.left > req_b;
        flags.hold_a    = seg_reg.left <= req_a && req_a <= seg_reg.right;
        flags.hold_b    = seg_reg.left <= req_b && req_b <= seg_reg.right;
    end

endmodule

### hw/rtl/interval_set_table_core.sv
// ----------------------------------------------------------------------------
// interval_set_table_core
// Sorted table of disjoint closed intervals with insert/merge, remove/split,
// point query and same-interval test, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Every request is compared against all cells combinationally. A query or
// same-interval test is evaluated, then handed off once the output is free.
// An insert or remove first moves the upper part of the table one cell per
// cycle along the chain, |d| cells in all, until the gap fits the new
// pieces, then writes them; d is the change in stored intervals: +1 at most
// for an insert or a remove, down to -MAX_INTERVALS when many intervals
// fuse or vanish. A rejected request leaves the table as it was. One
// request is in work at a time; the next is taken while a result waits.
module interval_set_table_core #(
    parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ist_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ist_pkg::rsp_item_t rsp,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);
    import ist_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t      state_reg;
    logic        merge_reg;
    logic [CW-1:0] count_reg;
    req_item_t   req_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [1:0]  np_reg;
    seg_t        piece0_reg;
    seg_t        piece1_reg;
    rsp_item_t   res_reg;
    rsp_item_t   rsp_reg;
    logic        rsp_valid_reg;

    seg_t        cell_seg   [MAX_INTERVALS];
    cell_flags_t cell_flags [MAX_INTERVALS];
    cell_op_t    cell_op    [MAX_INTERVALS];
    seg_t        cell_load  [MAX_INTERVALS];

    logic [MAX_INTERVALS-1:0] valid_v;
    logic [MAX_INTERVALS-1:0] below_v;
    logic [MAX_INTERVALS-1:0] keep_v;
    logic [MAX_INTERVALS-1:0] mid_v;
    logic [MAX_INTERVALS-1:0] hold_v;
    logic [CW-1:0] lo_c;
    logic [CW-1:0] hi_c;
    pos_t        first_left;
    pos_t        last_right;
    seg_t        hold_seg;
    logic        found_c;
    logic        same_c;
    logic        nonempty;
    logic        is_ins;
    logic        is_mod;
    logic        bad_range;
    logic        too_full;
    logic [1:0]  np_c;
    seg_t        piece0_c;
    seg_t        piece1_c;
    logic        cut_lo;
    logic        cut_hi;
    logic [CW-1:0] span_c;
    rsp_item_t   res_c;
    state_t      eval_state_c;

    // Row of cells
    for (genvar g = 0; g < MAX_INTERVALS; g++)
    begin : g_cell
        ist_cell u_cell (
            .clk        (clk),
            .op         (cell_op[g]),
            .from_left  (cell_seg[(g == 0) ? 0 : g - 1]),
            .from_right (cell_seg[(g == MAX_INTERVALS - 1) ? g : g + 1]),
            .load_seg   (cell_load[g]),
            .req_a      (req_reg.pos_a),
            .req_b      (req_reg.pos_b),
            .merge_adj  (merge_reg),
            .seg        (cell_seg[g]),
            .flags      (cell_flags[g])
        );
    end

    // Classify cells against the held request
    always_comb
    begin
        is_ins = req_reg.cmd == CMD_INSERT;
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            valid_v[i] = CW'(i) < count_reg;
            below_v[i] = valid_v[i] && (is_ins ? cell_flags[i].ins_below
                                               : cell_flags[i].rem_below);
            keep_v[i]  = valid_v[i] && !(is_ins ? cell_flags[i].ins_above
                                                : cell_flags[i].rem_above);
            hold_v[i]  = valid_v[i] && cell_flags[i].hold_a;
        end
        mid_v = keep_v & ~below_v;
    end

    // Find the edges of the affected run and select its end values
    always_comb
    begin
        lo_c       = '0;
        hi_c       = '0;
        first_left = '0;
        last_right = '0;
        hold_seg   = '0;
        same_c     = 1'b0;
        for (int i = 0; i <= MAX_INTERVALS; i++)
        begin
            if ((i == 0 || below_v[(i == 0) ? 0 : i - 1]) &&
                (i == MAX_INTERVALS || !below_v[(i == MAX_INTERVALS) ? 0 : i]))
                lo_c = lo_c | CW'(i);
            if ((i == 0 || keep_v[(i == 0) ? 0 : i - 1]) &&
                (i == MAX_INTERVALS || !keep_v[(i == MAX_INTERVALS) ? 0 : i]))
                hi_c = hi_c | CW'(i);
        end
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            if (mid_v[i] && (i == 0 || !mid_v[(i == 0) ? 0 : i - 1]))
                first_left = first_left | cell_seg[i].left;
            if (mid_v[i] && (i == MAX_INTERVALS - 1 ||
                             !mid_v[(i == MAX_INTERVALS - 1) ? i : i + 1]))
                last_right = last_right | cell_seg[i].right;
            if (hold_v[i])
            begin
                hold_seg = hold_seg | cell_seg[i];
                same_c   = same_c | cell_flags[i].hold_b;
            end
        end
        found_c  = |hold_v;
        nonempty = |mid_v;
    end

    // Build the replacement pieces and check capacity
    always_comb
    begin
        is_mod    = req_reg.cmd == CMD_INSERT || req_reg.cmd == CMD_REMOVE;
        bad_range = req_reg.pos_a > req_reg.pos_b;
        cut_lo    = first_left < req_reg.pos_a;
        cut_hi    = last_right > req_reg.pos_b;
        piece1_c  = '{left: req_reg.pos_b + POS_W'(1), right: last_right};
        if (is_ins)
        begin
            np_c = 2'd1;
            if (nonempty)
            begin
                piece0_c.left  = (first_left < req_reg.pos_a) ? first_left
                                                               : req_reg.pos_a;
                piece0_c.right = (last_right > req_reg.pos_b) ? last_right
                                                               : req_reg.pos_b;
            end
            else
            begin
                piece0_c = '{left: req_reg.pos_a, right: req_reg.pos_b};
            end
        end
        else
        begin
            np_c = nonempty ? (2'(cut_lo) + 2'(cut_hi)) : 2'd0;
            if (cut_lo)
                piece0_c = '{left: first_left, right: req_reg.pos_a - POS_W'(1)};
            else
                piece0_c = piece1_c;
        end
        too_full = ((CW+2)'(count_reg) + (CW+2)'(np_c)) >
                   ((CW+2)'(MAX_INTERVALS) + (CW+2)'(hi_c - lo_c));
    end

    // Form the result of the evaluate step and pick the next state
    always_comb
    begin
        res_c                = '0;
        res_c.interval_count = COUNT_W'(count_reg);
        eval_state_c         = S_DONE;
        if (is_mod)
        begin
            if (bad_range)
                res_c.status = ST_BAD_RANGE;
            else if (too_full)
                res_c.status = ST_FULL;
            else
                eval_state_c = S_SHIFT;
        end
        else if (req_reg.cmd == CMD_QUERY)
        begin
            res_c.found = found_c;
            if (found_c)
            begin
                res_c.seg_left  = hold_seg.left;
                res_c.seg_right = hold_seg.right;
            end
        end
        else
        begin
            res_c.same_interval = found_c && same_c;
        end
    end

    assign span_c = hi_reg - lo_reg;

    // Drive each cell: shift the upper part of the table or load the pieces
    always_comb
    begin
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            cell_op[i]   = CELL_HOLD;
            cell_load[i] = piece0_reg;
            if (state_reg == S_SHIFT)
            begin
                if (span_c < CW'(np_reg) &&
                    (CW+1)'(i) >= ((CW+1)'(hi_reg) + (CW+1)'(1)))
                    cell_op[i] = CELL_FROM_LEFT;
                else if (span_c > CW'(np_reg) &&
                         (CW+1)'(i) + (CW+1)'(1) >= (CW+1)'(hi_reg))
                    cell_op[i] = CELL_FROM_RIGHT;
            end
            else if (state_reg == S_WRITE)
            begin
                if (np_reg != 2'd0 && CW'(i) == lo_reg)
                    cell_op[i] = CELL_LOAD;
                else if (np_reg == 2'd2 && (CW+1)'(i) == (CW+1)'(lo_reg) + (CW+1)'(1))
                begin
                    cell_op[i]   = CELL_LOAD;
                    cell_load[i] = piece1_reg;
                end
            end
        end
    end

    // Sequence one request: evaluate, shift and write an accepted insert or remove, hand off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            merge_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                merge_reg <= cfg_wdata;
            // Raise the result on hand-off, drop it once taken
            if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    res_reg    <= res_c;
                    lo_reg     <= lo_c;
                    hi_reg     <= hi_c;
                    np_reg     <= np_c;
                    piece0_reg <= piece0_c;
                    piece1_reg <= piece1_c;
                    state_reg  <= eval_state_c;
                end
                S_SHIFT:
                begin
                    if (span_c < CW'(np_reg))
                    begin
                        hi_reg    <= hi_reg + CW'(1);
                        count_reg <= count_reg + CW'(1);
                    end
                    else if (span_c > CW'(np_reg))
                    begin
                        hi_reg    <= hi_reg - CW'(1);
                        count_reg <= count_reg - CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    res_reg.interval_count <= COUNT_W'(count_reg);
                    state_reg              <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Table never holds more than its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("stored count above capacity");

    // A found interval is well formed
    a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found) |-> (rsp.seg_left <= rsp.seg_right))
        else $error("found interval has left above right");

    // A rejected request carries no query or same result
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (!rsp.found && !rsp.same_interval))
        else $error("rejected item carries a lookup result");

endmodule
